@@ hw/rtl/tsem_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsem_pkg
// types and codes shared by the event merge top level and its store cells
// ----------------------------------------------------------------------------
package tsem_pkg;

  // input item kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // result kinds
  localparam logic [1:0] RK_HEADER = 2'd0;
  localparam logic [1:0] RK_EVENT  = 2'd1;
  localparam logic [1:0] RK_CLOSE  = 2'd2;

  localparam logic [63:0] NO_END_TIME = 64'hffff_ffff_ffff_ffff;

  // one stored event
  typedef struct packed {
    logic        valid;
    logic [63:0] id;
    logic [63:0] date;
    logic [63:0] dur;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // sorted insert of the new entry
    logic rel;   // shift toward the head, head entry leaves
  } cell_ctl_t;

endpackage

@@ hw/rtl/tsem_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsem_cell
// one slot of the sorted event chain: compares, keeps, takes the new entry or a neighbor
// ----------------------------------------------------------------------------
module tsem_cell (
  input  logic               clk,
  input  logic               rst,
  input  tsem_pkg::cell_ctl_t ctl,
  input  tsem_pkg::entry_t   new_entry,
  input  tsem_pkg::entry_t   left_entry,
  input  logic               left_h,
  input  tsem_pkg::entry_t   right_entry,
  output tsem_pkg::entry_t   entry,
  output logic               h
);

  tsem_pkg::entry_t entry_next;

  // slot is at or after the insert point: empty or strictly later date
  assign h = !entry.valid || (entry.date > new_entry.date);

  always_comb begin
    entry_next = entry;
    if (ctl.rel) begin
      entry_next = right_entry;
    end else if (ctl.ins) begin
      if (left_h) begin
        entry_next = left_entry;
      end else if (h) begin
        entry_next = new_entry;
        entry_next.valid = 1'b1;
      end
    end
  end

  // only the valid bit is reset, the payload follows it
  always_ff @(posedge clk) begin
    entry.id   <= entry_next.id;
    entry.date <= entry_next.date;
    entry.dur  <= entry_next.dur;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

@@ hw/rtl/timestamp_event_merge_watermark.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_event_merge_watermark
// merges timestamped events into one date-ordered stream, released by watermark
// ----------------------------------------------------------------------------
// event and end time transactions produce no result
// flush scans the end times of all inputs for their minimum, then decides, then
// forms each result in turn (header, released events, close) plus a step
// that finds the first event not yet due; output stalls hold the sequence
// a result appears on the output register the cycle after it is formed
// sync reset empties the chain, zeroes end times, watermark, header_sent, drop flag
module timestamp_event_merge_watermark #(
  parameter int NUM_INPUTS  = 4,
  parameter int STORE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [1:0]  input_index,
  input  logic [63:0] event_id,
  input  logic [63:0] event_date,
  input  logic [63:0] event_duration,
  input  logic [63:0] end_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [63:0] out_id,
  output logic [63:0] out_date,
  output logic [63:0] out_duration,
  output logic [63:0] chunk_start,
  output logic [63:0] chunk_end,
  output logic        dropped,
  output logic        last
);

  localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  // flush sequencer
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MIN   = 6'b000010,
    S_DEC   = 6'b000100,
    S_HDR   = 6'b001000,
    S_REL   = 6'b010000,
    S_CLOSE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [63:0] end_times [NUM_INPUTS];
  logic [63:0] watermark;
  logic [63:0] low;
  logic        chg;
  logic        header_sent;
  logic        drop_flag;
  logic [CW-1:0] store_count;
  logic [IW-1:0] min_idx;

  logic in_accept;
  logic can_load;
  logic rel_go;
  logic ins_go;
  logic [IW+1:0] idx_wide;

  tsem_pkg::cell_ctl_t ctl;
  tsem_pkg::entry_t    new_entry;
  tsem_pkg::entry_t    cells [STORE_DEPTH];
  logic                hs    [STORE_DEPTH];

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // output register is free, or its transaction completes this edge
  assign can_load  = !out_valid || !out_stall;
  assign idx_wide  = {{IW{1'b0}}, input_index};

  assign ins_go = in_accept && (kind == tsem_pkg::KIND_EVENT) &&
                  (store_count != CW'(STORE_DEPTH));
  // head of the chain is due while its date is before the new watermark
  assign rel_go = (state == S_REL) && can_load && cells[0].valid &&
                  (cells[0].date < low);

  assign ctl.ins = ins_go;
  assign ctl.rel = rel_go;

  always_comb begin
    new_entry       = '0;
    new_entry.valid = 1'b1;
    new_entry.id    = event_id;
    new_entry.date  = event_date;
    new_entry.dur   = event_duration;
  end

  // sorted chain of cells, head at index 0
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    tsem_pkg::entry_t left_e, right_e;
    logic             left_h;
    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_h = 1'b0;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_h = hs[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[i+1];
    end
    tsem_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_h      (left_h),
      .right_entry (right_e),
      .entry       (cells[i]),
      .h           (hs[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && kind == tsem_pkg::KIND_FLUSH) state_next = S_MIN;
      end
      S_MIN: begin
        if (min_idx == IW'(NUM_INPUTS - 1)) state_next = S_DEC;
      end
      S_DEC: begin
        if (!header_sent)        state_next = S_HDR;
        else if (low != watermark) state_next = S_REL;
        else                     state_next = S_IDLE;
      end
      S_HDR: begin
        if (can_load) state_next = chg ? S_REL : S_IDLE;
      end
      S_REL: begin
        if (can_load && !rel_go) state_next = S_CLOSE;
      end
      S_CLOSE: begin
        if (can_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      watermark   <= '0;
      header_sent <= 1'b0;
      drop_flag   <= 1'b0;
      store_count <= '0;
      out_valid   <= 1'b0;
      for (int k = 0; k < NUM_INPUTS; k++) end_times[k] <= '0;
    end else begin
      state <= state_next;
      if (in_accept && kind == tsem_pkg::KIND_EVENT && !ins_go) drop_flag <= 1'b1;
      if (in_accept && kind == tsem_pkg::KIND_END &&
          idx_wide < (IW+2)'(NUM_INPUTS)) begin
        end_times[idx_wide[IW-1:0]] <= end_time;
      end
      if (ins_go) store_count <= store_count + CW'(1);
      if (rel_go) store_count <= store_count - CW'(1);
      if (state == S_HDR && can_load) header_sent <= 1'b1;
      if (state == S_CLOSE && can_load) begin
        drop_flag <= 1'b0;
        watermark <= low;
      end
      // output register valid
      if ((state == S_HDR && can_load) || rel_go || (state == S_CLOSE && can_load)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // min scan over end times, one input a cycle
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      low     <= tsem_pkg::NO_END_TIME;
      min_idx <= '0;
    end else if (state == S_MIN) begin
      if (end_times[min_idx] < low) low <= end_times[min_idx];
      min_idx <= min_idx + IW'(1);
    end
    if (state == S_DEC) chg <= (low != watermark);
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == S_HDR && can_load) begin
      result_kind  <= tsem_pkg::RK_HEADER;
      out_id       <= '0;
      out_date     <= '0;
      out_duration <= '0;
      chunk_start  <= watermark;
      chunk_end    <= watermark;
      dropped      <= drop_flag;
      last         <= !chg;
    end else if (rel_go) begin
      result_kind  <= tsem_pkg::RK_EVENT;
      out_id       <= cells[0].id;
      out_date     <= cells[0].date;
      out_duration <= cells[0].dur;
      chunk_start  <= '0;
      chunk_end    <= '0;
      dropped      <= drop_flag;
      last         <= 1'b0;
    end else if (state == S_CLOSE && can_load) begin
      result_kind  <= tsem_pkg::RK_CLOSE;
      out_id       <= '0;
      out_date     <= '0;
      out_duration <= '0;
      chunk_start  <= watermark;
      chunk_end    <= low;
      dropped      <= drop_flag;
      last         <= 1'b1;
    end
  end

  // fill count never passes the chain length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    store_count <= CW'(STORE_DEPTH))
    else $error("store count beyond chain length");

  // head cell holds an event exactly when the count is nonzero
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    cells[0].valid == (store_count != '0))
    else $error("head cell and count disagree");

  // chain head stays in date order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cells[0].valid && cells[1].valid |-> cells[0].date <= cells[1].date)
    else $error("chain out of date order");

  // the header is the result shown when header_sent rises
  a_header: assert property (@(posedge clk) disable iff (rst)
    $rose(header_sent) |-> out_valid && result_kind == tsem_pkg::RK_HEADER)
    else $error("header_sent set without a header result");

endmodule
